// ===== sv/bfc_pkg.sv =====
// Package: types, constants and helpers shared by the box frustum cull files.
`timescale 1ns / 1ps
package bfc_pkg;

  localparam int MAX_PLANES = 6;
  localparam int COORD_BITS = 16;
  localparam int EXT_BITS   = COORD_BITS - 1;
  localparam int NORM_BITS  = 16;
  localparam int FRAC_BITS  = 14;
  localparam int PLANE_W    = 4 * NORM_BITS;
  localparam int PIDX_W     = 3;
  localparam int MASK_W     = 6;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = $clog2(MAX_PLANES + 1);
  localparam int CFG_DATA_W = PLANE_W;

  // Product and sum widths of the plane distance terms.
  localparam int PROD_W = NORM_BITS + COORD_BITS;
  localparam int ABS_W  = NORM_BITS + EXT_BITS;
  localparam int SUM_W  = PROD_W + 3;

  // Field positions inside a packed plane word.
  localparam int NX_LSB = 0;
  localparam int NY_LSB = NORM_BITS;
  localparam int NZ_LSB = 2 * NORM_BITS;
  localparam int D_LSB  = 3 * NORM_BITS;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = CFG_IDX_W'(0);
  localparam int                   REG_PLANE_BASE  = 1;

  localparam logic [CNT_W-1:0] PLANE_COUNT_RESET = CNT_W'(6);

  // Verdict codes.
  localparam logic [1:0] VERDICT_INSIDE     = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECTS = 2'd1;
  localparam logic [1:0] VERDICT_OUTSIDE    = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [EXT_BITS-1:0]          extent_x;
    logic [EXT_BITS-1:0]          extent_y;
    logic [EXT_BITS-1:0]          extent_z;
    logic [MASK_W-1:0]            in_mask;
    logic [PIDX_W-1:0]            last_plane;
  } box_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic [MASK_W-1:0] out_mask;
    logic [PIDX_W-1:0] reject_plane;
  } result_t;

  // Running verdict handed from cell to cell.
  typedef struct packed {
    logic [MASK_W-1:0] omask;
    logic              found;
    logic [PIDX_W-1:0] first_idx;
    logic              last_hit;
  } acc_t;

  typedef struct packed {
    box_t box;
    acc_t acc;
  } link_t;

  function automatic logic [NORM_BITS-1:0] abs_norm(input logic signed [NORM_BITS-1:0] v);
    logic [NORM_BITS-1:0] u;
    u = v;
    abs_norm = v[NORM_BITS-1] ? (~u + NORM_BITS'(1)) : u;
  endfunction

endpackage

// ===== sv/bfc_channels.sv =====
// Interfaces: valid/ready channels for box words and result words.
`timescale 1ns / 1ps
interface bfc_box_if;
  logic          valid;
  logic          ready;
  bfc_pkg::box_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bfc_result_if;
  logic             valid;
  logic             ready;
  bfc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bfc_cell.sv =====
// Cell: holds one plane and tests each passing box against it over two stages.
`timescale 1ns / 1ps
module bfc_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic [bfc_pkg::PIDX_W-1:0]     idx,
  input  logic                           in_use,
  input  logic                           load,
  input  logic [bfc_pkg::PLANE_W-1:0]    load_data,
  input  logic                           prev_valid,
  input  bfc_pkg::link_t                 prev_link,
  output logic                           valid,
  output bfc_pkg::link_t                 link
);

  logic [bfc_pkg::PLANE_W-1:0] plane;

  logic signed [bfc_pkg::NORM_BITS-1:0] nx, ny, nz, nd;
  logic [bfc_pkg::NORM_BITS-1:0]        ax, ay, az;

  logic                               s1_valid;
  bfc_pkg::link_t                     s1_link;
  logic signed [bfc_pkg::PROD_W-1:0]  px, py, pz;
  logic [bfc_pkg::ABS_W-1:0]          qx, qy, qz;

  logic signed [bfc_pkg::SUM_W-1:0] m, n, m_plus_n, m_minus_n;
  logic                             tested, outside, straddle;
  bfc_pkg::link_t                   link_next;

  assign nx = plane[bfc_pkg::NX_LSB +: bfc_pkg::NORM_BITS];
  assign ny = plane[bfc_pkg::NY_LSB +: bfc_pkg::NORM_BITS];
  assign nz = plane[bfc_pkg::NZ_LSB +: bfc_pkg::NORM_BITS];
  assign nd = plane[bfc_pkg::D_LSB +: bfc_pkg::NORM_BITS];
  assign ax = bfc_pkg::abs_norm(nx);
  assign ay = bfc_pkg::abs_norm(ny);
  assign az = bfc_pkg::abs_norm(nz);

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (load) begin
      plane <= load_data;
    end
  end

  // Stage one: the six products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_link <= prev_link;
      px <= bfc_pkg::PROD_W'(nx) * bfc_pkg::PROD_W'(prev_link.box.center_x);
      py <= bfc_pkg::PROD_W'(ny) * bfc_pkg::PROD_W'(prev_link.box.center_y);
      pz <= bfc_pkg::PROD_W'(nz) * bfc_pkg::PROD_W'(prev_link.box.center_z);
      qx <= bfc_pkg::ABS_W'(ax) * bfc_pkg::ABS_W'(prev_link.box.extent_x);
      qy <= bfc_pkg::ABS_W'(ay) * bfc_pkg::ABS_W'(prev_link.box.extent_y);
      qz <= bfc_pkg::ABS_W'(az) * bfc_pkg::ABS_W'(prev_link.box.extent_z);
    end
  end

  // Stage two: distance sums, the two sign tests and the merge into the running verdict.
  always_comb begin
    m = bfc_pkg::SUM_W'(px) + bfc_pkg::SUM_W'(py) + bfc_pkg::SUM_W'(pz)
      + (bfc_pkg::SUM_W'(nd) <<< bfc_pkg::FRAC_BITS);
    n = bfc_pkg::SUM_W'(qx) + bfc_pkg::SUM_W'(qy) + bfc_pkg::SUM_W'(qz);
    m_plus_n  = m + n;
    m_minus_n = m - n;
    outside   = m_plus_n[bfc_pkg::SUM_W-1];
    straddle  = m_minus_n[bfc_pkg::SUM_W-1];
    tested    = in_use && s1_link.box.in_mask[idx];

    link_next = s1_link;
    if (tested && outside) begin
      if (s1_link.box.last_plane == idx) begin
        link_next.acc.last_hit = 1'b1;
      end
      if (!s1_link.acc.found) begin
        link_next.acc.found     = 1'b1;
        link_next.acc.first_idx = idx;
      end
    end else if (tested && straddle) begin
      link_next.acc.omask[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      link <= link_next;
    end
  end

endmodule

// ===== sv/box_frustum_cull_coherent.sv =====
// Top level: box versus frustum culling with plane coherency, one cell per plane.
// Throughput: one box word per cycle while the chain is not held; each cell has its own multipliers.
// Backpressure: the whole chain holds while a result word waits and result.ready is low.
// Reset (synchronous, active high) empties the chain, sets plane_count to 6 and all planes to zero.
`timescale 1ns / 1ps
module box_frustum_cull_coherent (
  input  logic                              clk,
  input  logic                              rst,
  bfc_box_if.sink                           box,
  bfc_result_if.source                      result,
  input  logic                              wr_en,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [bfc_pkg::CFG_DATA_W-1:0]    wr_data
);

  // The chain moves as a whole: whenever the output register is empty or its word is being
  // taken, every stage shifts one place and a new box word may enter.
  logic adv;

  logic [bfc_pkg::CNT_W-1:0] plane_count;

  // Link g is the input of cell g; link MAX_PLANES is the output register of the last cell.
  logic           valid_chain [bfc_pkg::MAX_PLANES+1];
  bfc_pkg::link_t link_chain  [bfc_pkg::MAX_PLANES+1];

  logic                    last_outside;
  bfc_pkg::acc_t           fin_acc;
  bfc_pkg::box_t           fin_box;

  assign adv       = !valid_chain[bfc_pkg::MAX_PLANES] || result.ready;
  assign box.ready = adv;

  // A new box enters with an empty running verdict.
  assign valid_chain[0]   = box.valid;
  assign link_chain[0].box = box.data;
  assign link_chain[0].acc = '0;

  // The plane count register. Plane registers live inside their cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= bfc_pkg::PLANE_COUNT_RESET;
    end else if (wr_en && (wr_index == bfc_pkg::REG_PLANE_COUNT)) begin
      plane_count <= wr_data[bfc_pkg::CNT_W-1:0];
    end
  end

  // Each cell tests one plane. A cell is in use when its index lies below the plane count;
  // a count beyond the number of cells simply enables them all. Every plane in use and
  // enabled by in_mask is tested, so the remembered plane needs no separate first pass:
  // its own cell flags a rejection by it, and that takes priority at the end of the chain.
  for (genvar g = 0; g < bfc_pkg::MAX_PLANES; g++) begin : g_cell
    logic in_use;
    logic load;

    assign in_use = ((bfc_pkg::CNT_W + 1)'(g) < {1'b0, plane_count});
    assign load   = wr_en &&
                    (wr_index == bfc_pkg::CFG_IDX_W'(g + bfc_pkg::REG_PLANE_BASE));

    bfc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .idx        (bfc_pkg::PIDX_W'(g)),
      .in_use     (in_use),
      .load       (load),
      .load_data  (wr_data),
      .prev_valid (valid_chain[g]),
      .prev_link  (link_chain[g]),
      .valid      (valid_chain[g+1]),
      .link       (link_chain[g+1])
    );
  end

  // Final verdict. A rejection by the remembered plane wins; otherwise the lowest rejecting
  // plane is reported. With no rejection the remembered plane is passed back unchanged,
  // and the box is intersecting when it straddles any tested plane.
  assign fin_acc      = link_chain[bfc_pkg::MAX_PLANES].acc;
  assign fin_box      = link_chain[bfc_pkg::MAX_PLANES].box;
  assign last_outside = fin_acc.last_hit || fin_acc.found;

  always_comb begin
    result.valid = valid_chain[bfc_pkg::MAX_PLANES];
    if (last_outside) begin
      result.data.verdict      = bfc_pkg::VERDICT_OUTSIDE;
      result.data.out_mask     = '0;
      result.data.reject_plane = fin_acc.last_hit ? fin_box.last_plane : fin_acc.first_idx;
    end else begin
      result.data.verdict      = (|fin_acc.omask) ? bfc_pkg::VERDICT_INTERSECTS
                                                  : bfc_pkg::VERDICT_INSIDE;
      result.data.out_mask     = fin_acc.omask;
      result.data.reject_plane = fin_box.last_plane;
    end
  end

  // A hit on the remembered plane is always also a rejection seen by the chain.
  assert property (@(posedge clk) disable iff (rst)
    valid_chain[bfc_pkg::MAX_PLANES] && fin_acc.last_hit |-> fin_acc.found)
    else $error("remembered plane rejected but no rejection recorded");

  // The first rejecting plane recorded is always a real cell index.
  assert property (@(posedge clk) disable iff (rst)
    valid_chain[bfc_pkg::MAX_PLANES] && fin_acc.found
      |-> (fin_acc.first_idx < bfc_pkg::PIDX_W'(bfc_pkg::MAX_PLANES)))
    else $error("rejecting plane index out of range");

  // A write to the count register lands on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    wr_en && (wr_index == bfc_pkg::REG_PLANE_COUNT)
      |=> plane_count == $past(wr_data[bfc_pkg::CNT_W-1:0]))
    else $error("plane count write lost");

  // A stalled chain keeps its last word in place.
  assert property (@(posedge clk) disable iff (rst)
    valid_chain[bfc_pkg::MAX_PLANES] && !adv |=> $stable(link_chain[bfc_pkg::MAX_PLANES]))
    else $error("last cell changed while stalled");

endmodule
